### rtl/core/kelt_pkg.sv
`timescale 1ns / 1ps

package kelt_pkg;

    localparam int NAME_BYTES = 30;
    localparam int KIND_BYTES = 20;
    localparam int NAME_W     = 8 * NAME_BYTES;
    localparam int KIND_W     = 8 * KIND_BYTES;
    localparam int AMOUNT_W   = 32;
    localparam int FIELD_W    = 4;

    typedef logic [NAME_W-1:0] name_t;
    typedef logic [KIND_W-1:0] kind_t;

    typedef struct packed {
        name_t                      name;
        kind_t                      kind;
        logic signed [AMOUNT_W-1:0] amount;
    } entry_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LIST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // a byte survives only if every byte below it is non-zero
    function automatic name_t canon_name(input name_t raw);
        logic [NAME_BYTES-1:0] nz;
        logic [NAME_BYTES-1:0] mask;
        name_t                 res;
        for (int j = 0; j < NAME_BYTES; j++) begin
            nz[j] = |raw[8*j +: 8];
        end
        for (int j = 0; j < NAME_BYTES; j++) begin
            mask = {NAME_BYTES{1'b1}} >> (NAME_BYTES - j);
            res[8*j +: 8] = (&(nz | ~mask)) ? raw[8*j +: 8] : 8'h00;
        end
        return res;
    endfunction

    function automatic kind_t canon_kind(input kind_t raw);
        logic [KIND_BYTES-1:0] nz;
        logic [KIND_BYTES-1:0] mask;
        kind_t                 res;
        for (int j = 0; j < KIND_BYTES; j++) begin
            nz[j] = |raw[8*j +: 8];
        end
        for (int j = 0; j < KIND_BYTES; j++) begin
            mask = {KIND_BYTES{1'b1}} >> (KIND_BYTES - j);
            res[8*j +: 8] = (&(nz | ~mask)) ? raw[8*j +: 8] : 8'h00;
        end
        return res;
    endfunction

endpackage

### rtl/core/kelt_store.sv
`timescale 1ns / 1ps

module kelt_store
    import kelt_pkg::*;
#(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/kelt_cmp.sv
`timescale 1ns / 1ps

module kelt_cmp
    import kelt_pkg::*;
(
    input  logic  aclk,
    input  logic  load,
    input  name_t name_in,
    input  name_t entry_name,
    output name_t key,
    output logic  hit
);

    name_t key_reg;

    // key is held in trimmed form so stored names compare directly
    always_ff @(posedge aclk) begin
        if (load) begin
            key_reg <= canon_name(name_in);
        end
    end

    assign key = key_reg;
    assign hit = (key_reg == entry_name);

endmodule

### rtl/core/keyed_entry_list_table.sv
`timescale 1ns / 1ps

// channel   | handshake          | payload
// request   | s_valid / s_ready  | s_op, s_name_word0..3, s_kind_word0..2, s_amount
// result    | m_valid / m_ready  | m_status, m_out_name0..3, m_out_kind0..2, m_out_amount,
//           |                    | m_position, m_entries_now, m_last
//
// a request is accepted only while idle; insert then appends the new entry or reports
// full; search and remove read each entry in turn and check it with the shared name
// comparator, reporting a miss if none match, and remove then moves each later entry
// down one place; list emits each entry in order, or reports empty when the list is empty.
// s_ready is high only while the sequencer is idle; one request is in flight at a time.
// a stalled result holds the sequencer in the emitting state until m_ready.
// aresetn is synchronous and empties the list; entry contents are not cleared.

module keyed_entry_list_table
    import kelt_pkg::*;
#(
    parameter int CAPACITY = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [63:0]                s_name_word0,
    input  logic [63:0]                s_name_word1,
    input  logic [63:0]                s_name_word2,
    input  logic [47:0]                s_name_word3,
    input  logic [63:0]                s_kind_word0,
    input  logic [63:0]                s_kind_word1,
    input  logic [31:0]                s_kind_word2,
    input  logic signed [AMOUNT_W-1:0] s_amount,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [63:0]                m_out_name0,
    output logic [63:0]                m_out_name1,
    output logic [63:0]                m_out_name2,
    output logic [47:0]                m_out_name3,
    output logic [63:0]                m_out_kind0,
    output logic [63:0]                m_out_kind1,
    output logic [31:0]                m_out_kind2,
    output logic signed [AMOUNT_W-1:0] m_out_amount,
    output logic [FIELD_W-1:0]         m_position,
    output logic [FIELD_W-1:0]         m_entries_now,
    output logic                       m_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INSERT,
        S_MISS,
        S_FIND_RD,
        S_FIND_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST_RD,
        S_LIST_OUT
    } state_t;

    state_t                     state_reg, state_next;
    op_t                        op_reg, op_next;
    kind_t                      kind_reg, kind_next;
    logic signed [AMOUNT_W-1:0] amount_reg, amount_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       m_valid_reg, m_valid_next;
    status_t                    m_status_reg, m_status_next;
    entry_t                     out_entry_reg, out_entry_next;
    logic [FIELD_W-1:0]         m_position_reg, m_position_next;
    logic [FIELD_W-1:0]         m_entries_now_reg, m_entries_now_next;
    logic                       m_last_reg, m_last_next;

    logic          out_free;
    logic          key_load;
    logic          wr_en;
    logic          wr_shift;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        rd_data;
    entry_t        new_entry;
    name_t         key;
    logic          hit;
    logic [CW-1:0] addr_inc;

    kelt_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    kelt_cmp u_cmp (
        .aclk       (aclk),
        .load       (key_load),
        .name_in    ({s_name_word3, s_name_word2, s_name_word1, s_name_word0}),
        .entry_name (rd_data.name),
        .key        (key),
        .hit        (hit)
    );

    assign new_entry = '{name: key, kind: kind_reg, amount: amount_reg};
    assign wr_data   = wr_shift ? rd_data : new_entry;
    assign addr_inc  = CW'(addr_reg) + CW'(1);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);

    always_comb begin
        state_next         = state_reg;
        op_next            = op_reg;
        kind_next          = kind_reg;
        amount_next        = amount_reg;
        addr_next          = addr_reg;
        count_next         = count_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        out_entry_next     = out_entry_reg;
        m_position_next    = m_position_reg;
        m_entries_now_next = m_entries_now_reg;
        m_last_next        = m_last_reg;
        key_load           = 1'b0;
        wr_en              = 1'b0;
        wr_shift           = 1'b0;
        wr_addr            = addr_reg - AW'(1);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    key_load    = 1'b1;
                    op_next     = op_t'(s_op);
                    kind_next   = canon_kind({s_kind_word2, s_kind_word1, s_kind_word0});
                    amount_next = s_amount;
                    addr_next   = '0;
                    case (op_t'(s_op))
                        OP_INSERT:            state_next = S_INSERT;
                        OP_REMOVE, OP_SEARCH: state_next = (count_reg == '0) ? S_MISS : S_FIND_RD;
                        OP_LIST:              state_next = (count_reg == '0) ? S_MISS : S_LIST_RD;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_INSERT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                    if (count_reg >= CW'(CAPACITY)) begin
                        m_status_next      = ST_FULL;
                        out_entry_next     = '0;
                        m_position_next    = '0;
                        m_entries_now_next = FIELD_W'(count_reg);
                    end else begin
                        wr_en              = 1'b1;
                        wr_addr            = AW'(count_reg);
                        m_status_next      = ST_OK;
                        out_entry_next     = new_entry;
                        m_position_next    = FIELD_W'(count_reg);
                        m_entries_now_next = FIELD_W'(count_reg + CW'(1));
                        count_next         = count_reg + CW'(1);
                    end
                end
            end
            S_MISS: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_last_next        = 1'b1;
                    m_status_next      = (op_reg == OP_LIST) ? ST_EMPTY : ST_NOT_FOUND;
                    out_entry_next     = '0;
                    m_position_next    = '0;
                    m_entries_now_next = FIELD_W'(count_reg);
                    state_next         = S_IDLE;
                end
            end
            S_FIND_RD: begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (hit) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        m_last_next     = 1'b1;
                        m_status_next   = ST_OK;
                        out_entry_next  = rd_data;
                        m_position_next = FIELD_W'(addr_reg);
                        if (op_reg == OP_REMOVE) begin
                            m_entries_now_next = FIELD_W'(count_reg - CW'(1));
                            if (addr_inc < count_reg) begin
                                addr_next  = addr_reg + AW'(1);
                                state_next = S_SHIFT_RD;
                            end else begin
                                count_next = count_reg - CW'(1);
                                state_next = S_IDLE;
                            end
                        end else begin
                            m_entries_now_next = FIELD_W'(count_reg);
                            state_next         = S_IDLE;
                        end
                    end
                end else if (addr_inc >= count_reg) begin
                    state_next = S_MISS;
                end else begin
                    addr_next  = addr_reg + AW'(1);
                    state_next = S_FIND_RD;
                end
            end
            S_SHIFT_RD: begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // entry at addr moves down one place
                wr_en    = 1'b1;
                wr_shift = 1'b1;
                if (addr_inc < count_reg) begin
                    addr_next  = addr_reg + AW'(1);
                    state_next = S_SHIFT_RD;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_IDLE;
                end
            end
            S_LIST_RD: begin
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = ST_OK;
                    out_entry_next     = rd_data;
                    m_position_next    = FIELD_W'(addr_reg);
                    m_entries_now_next = FIELD_W'(count_reg);
                    m_last_next        = (addr_inc == count_reg);
                    if (addr_inc == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        addr_next  = addr_reg + AW'(1);
                        state_next = S_LIST_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg            <= op_next;
        kind_reg          <= kind_next;
        amount_reg        <= amount_next;
        addr_reg          <= addr_next;
        m_status_reg      <= m_status_next;
        out_entry_reg     <= out_entry_next;
        m_position_reg    <= m_position_next;
        m_entries_now_reg <= m_entries_now_next;
        m_last_reg        <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_name0   = out_entry_reg.name[63:0];
    assign m_out_name1   = out_entry_reg.name[127:64];
    assign m_out_name2   = out_entry_reg.name[191:128];
    assign m_out_name3   = out_entry_reg.name[239:192];
    assign m_out_kind0   = out_entry_reg.kind[63:0];
    assign m_out_kind1   = out_entry_reg.kind[127:64];
    assign m_out_kind2   = out_entry_reg.kind[159:128];
    assign m_out_amount  = out_entry_reg.amount;
    assign m_position    = m_position_reg;
    assign m_entries_now = m_entries_now_reg;
    assign m_last        = m_last_reg;

endmodule

### rtl/core/kelt_checker.sv
`timescale 1ns / 1ps

module kelt_checker
    import kelt_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_status,
    input logic signed [AMOUNT_W-1:0] m_out_amount,
    input logic [FIELD_W-1:0]         m_position,
    input logic                       m_last
);

    // one request at a time: the sequencer leaves idle on accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one in flight");

    // only ok results can be part of a multi-result listing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_last)
        else $error("error status not marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_position == '0) && (m_out_amount == '0))
        else $error("error result carries entry fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_position))
        else $error("stalled result changed");

endmodule

bind keyed_entry_list_table kelt_checker u_kelt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_out_amount (m_out_amount),
    .m_position   (m_position),
    .m_last       (m_last)
);
